/* design/udsfota_pkg.sv */
// Shared types and constants of the diagnostic server with firmware-update flow.
package udsfota_pkg;

  // Largest request length that is processed at all
  localparam int unsigned RxMaxBytes = 4095;

  // Configuration port
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CfgMaxBlock   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCounterWrap = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLengthFmt  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgVerifyId   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgActivateId = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRollbackId = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgStatusId   = 3'd6;

  // Service identifiers
  localparam logic [7:0] SidSession  = 8'h10;
  localparam logic [7:0] SidReset    = 8'h11;
  localparam logic [7:0] SidTester   = 8'h3E;
  localparam logic [7:0] SidDownload = 8'h34;
  localparam logic [7:0] SidTransfer = 8'h36;
  localparam logic [7:0] SidExit     = 8'h37;
  localparam logic [7:0] SidRoutine  = 8'h31;
  localparam logic [7:0] SidReadId   = 8'h22;

  // Positive response identifiers
  localparam logic [7:0] PosSession  = 8'h50;
  localparam logic [7:0] PosReset    = 8'h51;
  localparam logic [7:0] PosTester   = 8'h7E;
  localparam logic [7:0] PosDownload = 8'h74;
  localparam logic [7:0] PosTransfer = 8'h76;
  localparam logic [7:0] PosExit     = 8'h77;
  localparam logic [7:0] PosRoutine  = 8'h71;
  localparam logic [7:0] PosReadId   = 8'h62;

  // Negative response and its codes
  localparam logic [7:0] NegSid  = 8'h7F;
  localparam logic [7:0] NrcSns  = 8'h11;
  localparam logic [7:0] NrcSfns = 8'h12;
  localparam logic [7:0] NrcLen  = 8'h13;
  localparam logic [7:0] NrcCnc  = 8'h22;
  localparam logic [7:0] NrcSeq  = 8'h24;
  localparam logic [7:0] NrcRor  = 8'h31;

  // Session timing bytes of the session control response
  localparam logic [7:0] P2High     = 8'h00;
  localparam logic [7:0] P2Low      = 8'h32;
  localparam logic [7:0] P2StarHigh = 8'h01;
  localparam logic [7:0] P2StarLow  = 8'hF4;

  // Subfunctions
  localparam logic [7:0] SubDefault     = 8'h01;
  localparam logic [7:0] SubProgramming = 8'h02;
  localparam logic [7:0] SubExtended    = 8'h03;
  localparam logic [7:0] SubHardReset   = 8'h01;
  localparam logic [7:0] SubStart       = 8'h01;
  localparam logic [7:0] SubZero        = 8'h00;

  // Sessions
  localparam logic [1:0] SessDefault     = 2'd0;
  localparam logic [1:0] SessExtended    = 2'd1;
  localparam logic [1:0] SessProgramming = 2'd2;

  // Update flow states
  localparam logic [3:0] StIdle      = 4'd0;
  localparam logic [3:0] StExt       = 4'd1;
  localparam logic [3:0] StAccepted  = 4'd2;
  localparam logic [3:0] StXfer      = 4'd3;
  localparam logic [3:0] StDone      = 4'd4;
  localparam logic [3:0] StVerified  = 4'd5;
  localparam logic [3:0] StProg      = 4'd6;
  localparam logic [3:0] StPending   = 4'd7;
  localparam logic [3:0] StActivated = 4'd8;
  localparam logic [3:0] StRollback  = 4'd9;
  localparam logic [3:0] StFailed    = 4'd10;

  // Last result codes
  localparam logic [2:0] ResNone  = 3'd0;
  localparam logic [2:0] ResOk    = 3'd1;
  localparam logic [2:0] ResFail  = 3'd2;
  localparam logic [2:0] ResXfail = 3'd3;
  localparam logic [2:0] ResRb    = 3'd4;

  // Reset values of the configuration registers
  localparam logic [11:0] RstMaxBlock    = 12'd4095;
  localparam logic [7:0]  RstCounterWrap = 8'd255;
  localparam logic [7:0]  RstLengthFmt   = 8'h30;
  localparam logic [15:0] RstVerifyId    = 16'hFF01;
  localparam logic [15:0] RstActivateId  = 16'hFF02;
  localparam logic [15:0] RstRollbackId  = 16'hFF03;
  localparam logic [15:0] RstStatusId    = 16'hF180;

  // Class of a word as seen by the front end
  typedef enum logic [3:0] {
    KindConfirm,
    KindIgnore,
    KindSession,
    KindReset,
    KindTester,
    KindDownload,
    KindTransfer,
    KindExit,
    KindRoutine,
    KindReadId,
    KindUnsupported
  } kind_t;

  // Which configured routine a routine control request names
  typedef enum logic [1:0] {
    RtNone,
    RtVerify,
    RtActivate,
    RtRollback
  } rt_sel_t;

  typedef struct packed {
    logic [11:0] max_block_length;
    logic [7:0]  counter_wrap_value;
    logic [7:0]  length_format_code;
    logic [15:0] verify_routine_id;
    logic [15:0] activate_routine_id;
    logic [15:0] rollback_routine_id;
    logic [15:0] status_identifier;
  } cfg_t;

  // Classified word passed from front to back
  typedef struct packed {
    kind_t      kind;
    logic       tx_ok;
    logic       len_bad;
    logic       len_over;
    rt_sel_t    rt_sel;
    logic       status_hit;
    logic [7:0] sid;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } cmd_t;

  typedef struct packed {
    logic [2:0] resp_length;
    logic [7:0] resp_b0;
    logic [7:0] resp_b1;
    logic [7:0] resp_b2;
    logic [7:0] resp_b3;
    logic [7:0] resp_b4;
    logic [7:0] resp_b5;
    logic [1:0] session;
    logic [3:0] update_state;
    logic [2:0] last_result;
  } res_t;

endpackage

/* design/udsfota_ifs.sv */
// Request and response channel interfaces of the diagnostic server.
interface udsfota_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [11:0] req_length;
  logic [7:0]  sid;
  logic [7:0]  byte_one;
  logic [7:0]  byte_two;
  logic [7:0]  byte_three;
  logic        tx_ok;

  modport source (
    output valid, mode, req_length, sid, byte_one, byte_two, byte_three, tx_ok,
    input  ready
  );
  modport sink (
    input  valid, mode, req_length, sid, byte_one, byte_two, byte_three, tx_ok,
    output ready
  );
endinterface

interface udsfota_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] resp_length;
  logic [7:0] resp_b0;
  logic [7:0] resp_b1;
  logic [7:0] resp_b2;
  logic [7:0] resp_b3;
  logic [7:0] resp_b4;
  logic [7:0] resp_b5;
  logic [1:0] session;
  logic [3:0] update_state;
  logic [2:0] last_result;

  modport source (
    output valid, resp_length, resp_b0, resp_b1, resp_b2, resp_b3, resp_b4, resp_b5,
           session, update_state, last_result,
    input  ready
  );
  modport sink (
    input  valid, resp_length, resp_b0, resp_b1, resp_b2, resp_b3, resp_b4, resp_b5,
           session, update_state, last_result,
    output ready
  );
endinterface

/* design/udsfota_front.sv */
// Front end: accepts request and confirmation words and classifies them.
module udsfota_front (
  udsfota_req_if.sink           req,
  input  udsfota_pkg::cfg_t     cfg,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output udsfota_pkg::cmd_t     cmd
);

  logic                  len_in_range;
  logic [15:0]           routine_id;
  logic [15:0]           read_id;
  udsfota_pkg::kind_t    kind;
  logic                  len_bad;
  udsfota_pkg::rt_sel_t  rt_sel;

  // Pass the handshake straight to the queue
  assign cmd_valid = req.valid;
  assign req.ready = cmd_ready;

  assign len_in_range = (req.req_length != 12'd0) &&
                        (17'(req.req_length) <= 17'(udsfota_pkg::RxMaxBytes));
  assign routine_id = {req.byte_two, req.byte_three};
  assign read_id    = {req.byte_one, req.byte_two};

  // Classify the service and apply its length rule
  always_comb begin
    kind    = udsfota_pkg::KindUnsupported;
    len_bad = 1'b0;
    if (req.mode) begin
      kind = udsfota_pkg::KindConfirm;
    end else if (!len_in_range) begin
      kind = udsfota_pkg::KindIgnore;
    end else begin
      unique case (req.sid)
        udsfota_pkg::SidSession: begin
          kind    = udsfota_pkg::KindSession;
          len_bad = req.req_length < 12'd2;
        end
        udsfota_pkg::SidReset: begin
          kind    = udsfota_pkg::KindReset;
          len_bad = req.req_length < 12'd2;
        end
        udsfota_pkg::SidTester: begin
          kind    = udsfota_pkg::KindTester;
          len_bad = req.req_length < 12'd2;
        end
        udsfota_pkg::SidDownload: begin
          kind    = udsfota_pkg::KindDownload;
          len_bad = req.req_length < 12'd5;
        end
        udsfota_pkg::SidTransfer: begin
          kind    = udsfota_pkg::KindTransfer;
          len_bad = req.req_length < 12'd2;
        end
        udsfota_pkg::SidExit: begin
          kind    = udsfota_pkg::KindExit;
        end
        udsfota_pkg::SidRoutine: begin
          kind    = udsfota_pkg::KindRoutine;
          len_bad = req.req_length < 12'd4;
        end
        udsfota_pkg::SidReadId: begin
          kind    = udsfota_pkg::KindReadId;
          len_bad = req.req_length != 12'd3;
        end
        default: begin
          kind    = udsfota_pkg::KindUnsupported;
        end
      endcase
    end
  end

  // Match the routine identifier, verify first, then activate, then rollback
  always_comb begin
    priority if (routine_id == cfg.verify_routine_id) begin
      rt_sel = udsfota_pkg::RtVerify;
    end else if (routine_id == cfg.activate_routine_id) begin
      rt_sel = udsfota_pkg::RtActivate;
    end else if (routine_id == cfg.rollback_routine_id) begin
      rt_sel = udsfota_pkg::RtRollback;
    end else begin
      rt_sel = udsfota_pkg::RtNone;
    end
  end

  assign cmd.kind       = kind;
  assign cmd.tx_ok      = req.tx_ok;
  assign cmd.len_bad    = len_bad;
  assign cmd.len_over   = req.req_length > cfg.max_block_length;
  assign cmd.rt_sel     = rt_sel;
  assign cmd.status_hit = read_id == cfg.status_identifier;
  assign cmd.sid        = req.sid;
  assign cmd.b1         = req.byte_one;
  assign cmd.b2         = req.byte_two;
  assign cmd.b3         = req.byte_three;

endmodule

/* design/udsfota_queue.sv */
// Short register queue between the front end and the back end.
module udsfota_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  udsfota_pkg::cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output udsfota_pkg::cmd_t pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  udsfota_pkg::cmd_t slots [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = count != Full;
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

/* design/udsfota_back.sv */
// Back end: runs the services, keeps session and update flow, registers the result.
module udsfota_back (
  input  logic              clk,
  input  logic              rst,
  input  udsfota_pkg::cfg_t cfg,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  udsfota_pkg::cmd_t cmd,
  udsfota_rsp_if.source     rsp
);

  logic [1:0] session;
  logic [1:0] session_next;
  logic [3:0] ustate;
  logic [3:0] ustate_next;
  logic [2:0] last_result;
  logic [2:0] last_result_next;
  logic [7:0] exp_counter;
  logic [7:0] exp_counter_next;
  logic       report_pending;
  logic       report_pending_next;
  logic       idle_pending;
  logic       idle_pending_next;

  logic              out_valid;
  udsfota_pkg::res_t out_res;
  udsfota_pkg::res_t res_next;

  logic       pop;
  logic       is_neg;
  logic [7:0] nrc;
  logic [7:0] sub;
  logic       start_state;

  assign pop       = cmd_valid && (!out_valid || rsp.ready);
  assign cmd_ready = !out_valid || rsp.ready;
  assign sub       = {1'b0, cmd.b1[6:0]};
  assign start_state = (ustate == udsfota_pkg::StIdle) || (ustate == udsfota_pkg::StExt) ||
                       (ustate == udsfota_pkg::StRollback);

  // Carry out one word against the current state
  always_comb begin
    session_next        = session;
    ustate_next         = ustate;
    last_result_next    = last_result;
    exp_counter_next    = exp_counter;
    report_pending_next = report_pending;
    idle_pending_next   = idle_pending;
    res_next            = '0;
    is_neg              = 1'b0;
    nrc                 = udsfota_pkg::NrcSns;

    unique case (cmd.kind)
      udsfota_pkg::KindConfirm: begin
        if (!cmd.tx_ok) begin
          last_result_next = udsfota_pkg::ResFail;
          if (ustate != udsfota_pkg::StIdle && ustate != udsfota_pkg::StActivated) begin
            ustate_next = udsfota_pkg::StFailed;
          end
        end else if (idle_pending) begin
          ustate_next         = udsfota_pkg::StIdle;
          exp_counter_next    = 8'd1;
          idle_pending_next   = 1'b0;
          report_pending_next = 1'b0;
        end
      end
      udsfota_pkg::KindIgnore: begin
      end
      udsfota_pkg::KindSession: begin
        if (cmd.len_bad) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcLen;
        end else if (sub == udsfota_pkg::SubDefault) begin
          session_next = udsfota_pkg::SessDefault;
        end else if (sub == udsfota_pkg::SubExtended) begin
          session_next = udsfota_pkg::SessExtended;
          if (start_state) begin
            ustate_next = udsfota_pkg::StExt;
          end
        end else if (sub == udsfota_pkg::SubProgramming) begin
          if (ustate != udsfota_pkg::StVerified && ustate != udsfota_pkg::StProg) begin
            is_neg = 1'b1;
            nrc    = udsfota_pkg::NrcCnc;
          end else begin
            session_next = udsfota_pkg::SessProgramming;
            ustate_next  = udsfota_pkg::StProg;
          end
        end else begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcSfns;
        end
        res_next.resp_length = 3'd6;
        res_next.resp_b0     = udsfota_pkg::PosSession;
        res_next.resp_b1     = sub;
        res_next.resp_b2     = udsfota_pkg::P2High;
        res_next.resp_b3     = udsfota_pkg::P2Low;
        res_next.resp_b4     = udsfota_pkg::P2StarHigh;
        res_next.resp_b5     = udsfota_pkg::P2StarLow;
      end
      udsfota_pkg::KindReset: begin
        if (cmd.len_bad) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcLen;
        end else if (sub != udsfota_pkg::SubHardReset) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcSfns;
        end else if (ustate == udsfota_pkg::StPending) begin
          ustate_next         = udsfota_pkg::StActivated;
          last_result_next    = udsfota_pkg::ResOk;
          report_pending_next = 1'b1;
        end
        res_next.resp_length = 3'd2;
        res_next.resp_b0     = udsfota_pkg::PosReset;
        res_next.resp_b1     = sub;
      end
      udsfota_pkg::KindTester: begin
        if (cmd.len_bad) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcLen;
        end else if (sub != udsfota_pkg::SubZero) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcSfns;
        end
        res_next.resp_length = 3'd2;
        res_next.resp_b0     = udsfota_pkg::PosTester;
      end
      udsfota_pkg::KindDownload: begin
        if (cmd.len_bad) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcLen;
        end else if (session != udsfota_pkg::SessExtended) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcCnc;
        end else if (!start_state) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcSeq;
        end else begin
          exp_counter_next    = 8'd1;
          idle_pending_next   = 1'b0;
          report_pending_next = 1'b0;
          ustate_next         = udsfota_pkg::StAccepted;
          last_result_next    = udsfota_pkg::ResNone;
        end
        res_next.resp_length = 3'd5;
        res_next.resp_b0     = udsfota_pkg::PosDownload;
        res_next.resp_b1     = cfg.length_format_code;
        res_next.resp_b3     = {4'd0, cfg.max_block_length[11:8]};
        res_next.resp_b4     = cfg.max_block_length[7:0];
      end
      udsfota_pkg::KindTransfer: begin
        if (cmd.len_bad) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcLen;
        end else if (cmd.len_over) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcRor;
        end else if (ustate != udsfota_pkg::StAccepted && ustate != udsfota_pkg::StXfer) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcSeq;
        end else if (cmd.b1 != exp_counter) begin
          // Wrong block counter aborts the transfer
          ustate_next      = udsfota_pkg::StFailed;
          last_result_next = udsfota_pkg::ResXfail;
          is_neg           = 1'b1;
          nrc              = udsfota_pkg::NrcSeq;
        end else begin
          ustate_next      = udsfota_pkg::StXfer;
          exp_counter_next = (exp_counter == cfg.counter_wrap_value) ? 8'd0
                                                                      : exp_counter + 8'd1;
        end
        res_next.resp_length = 3'd2;
        res_next.resp_b0     = udsfota_pkg::PosTransfer;
        res_next.resp_b1     = cmd.b1;
      end
      udsfota_pkg::KindExit: begin
        if (ustate != udsfota_pkg::StXfer) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcSeq;
        end else begin
          ustate_next = udsfota_pkg::StDone;
        end
        res_next.resp_length = 3'd1;
        res_next.resp_b0     = udsfota_pkg::PosExit;
      end
      udsfota_pkg::KindRoutine: begin
        if (cmd.len_bad) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcLen;
        end else if (sub != udsfota_pkg::SubStart) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcSfns;
        end else begin
          unique case (cmd.rt_sel)
            udsfota_pkg::RtVerify: begin
              if (ustate != udsfota_pkg::StDone) begin
                is_neg = 1'b1;
                nrc    = udsfota_pkg::NrcSeq;
              end else begin
                ustate_next = udsfota_pkg::StVerified;
              end
            end
            udsfota_pkg::RtActivate: begin
              if (ustate != udsfota_pkg::StProg) begin
                is_neg = 1'b1;
                nrc    = udsfota_pkg::NrcSeq;
              end else begin
                ustate_next = udsfota_pkg::StPending;
              end
            end
            udsfota_pkg::RtRollback: begin
              ustate_next         = udsfota_pkg::StRollback;
              last_result_next    = udsfota_pkg::ResRb;
              report_pending_next = 1'b1;
              idle_pending_next   = 1'b0;
            end
            default: begin
              is_neg = 1'b1;
              nrc    = udsfota_pkg::NrcRor;
            end
          endcase
        end
        res_next.resp_length = 3'd4;
        res_next.resp_b0     = udsfota_pkg::PosRoutine;
        res_next.resp_b1     = sub;
        res_next.resp_b2     = cmd.b2;
        res_next.resp_b3     = cmd.b3;
      end
      udsfota_pkg::KindReadId: begin
        if (cmd.len_bad) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcLen;
        end else if (!cmd.status_hit) begin
          is_neg = 1'b1;
          nrc    = udsfota_pkg::NrcRor;
        end else if ((ustate == udsfota_pkg::StActivated ||
                      ustate == udsfota_pkg::StRollback) && report_pending) begin
          // Hand the outcome report over, then wait for the confirmation
          report_pending_next = 1'b0;
          idle_pending_next   = 1'b1;
        end
        res_next.resp_length = 3'd5;
        res_next.resp_b0     = udsfota_pkg::PosReadId;
        res_next.resp_b1     = cmd.b1;
        res_next.resp_b2     = cmd.b2;
        res_next.resp_b3     = {4'd0, ustate};
        res_next.resp_b4     = {5'd0, last_result};
      end
      default: begin
        is_neg = 1'b1;
        nrc    = udsfota_pkg::NrcSns;
      end
    endcase

    // Replace the positive bytes by a negative response
    if (is_neg) begin
      res_next.resp_length = 3'd3;
      res_next.resp_b0     = udsfota_pkg::NegSid;
      res_next.resp_b1     = cmd.sid;
      res_next.resp_b2     = nrc;
      res_next.resp_b3     = 8'd0;
      res_next.resp_b4     = 8'd0;
      res_next.resp_b5     = 8'd0;
    end

    res_next.session      = session_next;
    res_next.update_state = ustate_next;
    res_next.last_result  = last_result_next;
  end

  // Commit the state of a word taken from the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      session        <= udsfota_pkg::SessDefault;
      ustate         <= udsfota_pkg::StIdle;
      last_result    <= udsfota_pkg::ResNone;
      exp_counter    <= 8'd1;
      report_pending <= 1'b0;
      idle_pending   <= 1'b0;
    end else if (pop) begin
      session        <= session_next;
      ustate         <= ustate_next;
      last_result    <= last_result_next;
      exp_counter    <= exp_counter_next;
      report_pending <= report_pending_next;
      idle_pending   <= idle_pending_next;
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.resp_length  = out_res.resp_length;
  assign rsp.resp_b0      = out_res.resp_b0;
  assign rsp.resp_b1      = out_res.resp_b1;
  assign rsp.resp_b2      = out_res.resp_b2;
  assign rsp.resp_b3      = out_res.resp_b3;
  assign rsp.resp_b4      = out_res.resp_b4;
  assign rsp.resp_b5      = out_res.resp_b5;
  assign rsp.session      = out_res.session;
  assign rsp.update_state = out_res.update_state;
  assign rsp.last_result  = out_res.last_result;

endmodule

/* design/uds_fota_diagnostic_server_top.sv */
// Latency: an accepted word is stored in a queue slot, and the back end then registers its result word.
// Throughput: one word per cycle while the sink is ready; the queue and the result
// register let either side stall alone, and every word yields exactly one result word.
// The rate is set by the back end, which commits one word's state per cycle.
// Reset (rst, synchronous) clears session, update state, last result, flags,
// the queue and the result register, sets the block counter to one and restores
// all configuration registers to their defaults; no clearing pass follows.
module uds_fota_diagnostic_server_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  udsfota_req_if.sink                           req,
  udsfota_rsp_if.source                         rsp,
  input  logic                                  cfg_we,
  input  logic [udsfota_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [udsfota_pkg::CfgDataW-1:0]      cfg_data
);

  udsfota_pkg::cfg_t cfg;
  udsfota_pkg::cmd_t front_cmd;
  udsfota_pkg::cmd_t back_cmd;
  logic              front_valid;
  logic              front_ready;
  logic              back_valid;
  logic              back_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_block_length    <= udsfota_pkg::RstMaxBlock;
      cfg.counter_wrap_value  <= udsfota_pkg::RstCounterWrap;
      cfg.length_format_code  <= udsfota_pkg::RstLengthFmt;
      cfg.verify_routine_id   <= udsfota_pkg::RstVerifyId;
      cfg.activate_routine_id <= udsfota_pkg::RstActivateId;
      cfg.rollback_routine_id <= udsfota_pkg::RstRollbackId;
      cfg.status_identifier   <= udsfota_pkg::RstStatusId;
    end else if (cfg_we) begin
      unique case (cfg_index)
        udsfota_pkg::CfgMaxBlock:    cfg.max_block_length    <= cfg_data[11:0];
        udsfota_pkg::CfgCounterWrap: cfg.counter_wrap_value  <= cfg_data[7:0];
        udsfota_pkg::CfgLengthFmt:   cfg.length_format_code  <= cfg_data[7:0];
        udsfota_pkg::CfgVerifyId:    cfg.verify_routine_id   <= cfg_data;
        udsfota_pkg::CfgActivateId:  cfg.activate_routine_id <= cfg_data;
        udsfota_pkg::CfgRollbackId:  cfg.rollback_routine_id <= cfg_data;
        udsfota_pkg::CfgStatusId:    cfg.status_identifier   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  udsfota_front u_front (
    .req       (req),
    .cfg       (cfg),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  udsfota_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  udsfota_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .rsp       (rsp)
  );

  // A three-byte result is always a negative response and vice versa
  a_neg_length : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.resp_length == 3'd3) == (rsp.resp_b0 == udsfota_pkg::NegSid)))
    else $error("negative response length mismatch");

  // Byte five reads as zero unless the response is six bytes long
  a_tail_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.resp_length != 3'd6) |-> (rsp.resp_b5 == 8'd0))
    else $error("response byte beyond length not cleared");

  // No result is offered in the cycle after reset
  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("result valid right after reset");

  // A word that enters an empty queue passes through it before it shows up as a result; there is no bypass
  a_no_bypass : assert property (@(posedge clk) disable iff (rst)
    (!back_valid && !rsp.valid) |=> !rsp.valid)
    else $error("result appeared without a queued word");

endmodule

/* tb/sv/uds_fota_diagnostic_server_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the diagnostic server: directed and random traffic with a predictor.
module uds_fota_diagnostic_server_top_tb;
  import udsfota_pkg::*;

  // One request or confirmation word as the sender sees it
  typedef struct packed {
    logic        mode;
    logic [11:0] req_length;
    logic [7:0]  sid;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic        tx_ok;
  } diag_word_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  udsfota_req_if req_ch ();
  udsfota_rsp_if rsp_ch ();

  uds_fota_diagnostic_server_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor state: session, update flow, last result, block counter, flags
  logic [1:0] sess_q;
  logic [3:0] flow_q;
  logic [2:0] outcome_q;
  logic [7:0] blk_ctr;
  logic       report_q;
  logic       idle_q;
  cfg_t       cfg_q;

  res_t answers_due[$];
  int   mismatches = 0;
  int   idle_pct;
  int   hold_left = 0;

  function automatic void reset_model();
    sess_q    = SessDefault;
    flow_q    = StIdle;
    outcome_q = ResNone;
    blk_ctr   = 8'd1;
    report_q  = 1'b0;
    idle_q    = 1'b0;
    cfg_q.max_block_length    = RstMaxBlock;
    cfg_q.counter_wrap_value  = RstCounterWrap;
    cfg_q.length_format_code  = RstLengthFmt;
    cfg_q.verify_routine_id   = RstVerifyId;
    cfg_q.activate_routine_id = RstActivateId;
    cfg_q.rollback_routine_id = RstRollbackId;
    cfg_q.status_identifier   = RstStatusId;
  endfunction

  function automatic logic may_start(input logic [3:0] st);
    return st == StIdle || st == StExt || st == StRollback;
  endfunction

  function automatic void restart_flow();
    blk_ctr  = 8'd1;
    idle_q   = 1'b0;
    report_q = 1'b0;
  endfunction

  function automatic res_t refuse(input logic [7:0] sid, input logic [7:0] nrc);
    res_t r;
    r = '0;
    r.resp_length = 3'd3;
    r.resp_b0     = NegSid;
    r.resp_b1     = sid;
    r.resp_b2     = nrc;
    return r;
  endfunction

  // Response bytes of one request; updates the flow state on the way
  function automatic res_t answer_request(input diag_word_t w);
    res_t        r;
    logic [7:0]  sub;
    logic [15:0] rid;
    r   = '0;
    sub = w.byte_one & 8'h7F;
    case (w.sid)
      SidSession: begin
        if (w.req_length < 12'd2) return refuse(w.sid, NrcLen);
        if (sub == SubDefault) begin
          sess_q = SessDefault;
        end else if (sub == SubExtended) begin
          sess_q = SessExtended;
          if (may_start(flow_q)) flow_q = StExt;
        end else if (sub == SubProgramming) begin
          if (flow_q != StVerified && flow_q != StProg) return refuse(w.sid, NrcCnc);
          sess_q = SessProgramming;
          flow_q = StProg;
        end else begin
          return refuse(w.sid, NrcSfns);
        end
        r.resp_length = 3'd6;
        r.resp_b0 = PosSession;
        r.resp_b1 = sub;
        r.resp_b2 = P2High;
        r.resp_b3 = P2Low;
        r.resp_b4 = P2StarHigh;
        r.resp_b5 = P2StarLow;
      end
      SidReset: begin
        if (w.req_length < 12'd2) return refuse(w.sid, NrcLen);
        if (sub != SubHardReset) return refuse(w.sid, NrcSfns);
        if (flow_q == StPending) begin
          flow_q    = StActivated;
          outcome_q = ResOk;
          report_q  = 1'b1;
        end
        r.resp_length = 3'd2;
        r.resp_b0 = PosReset;
        r.resp_b1 = sub;
      end
      SidTester: begin
        if (w.req_length < 12'd2) return refuse(w.sid, NrcLen);
        if (sub != SubZero) return refuse(w.sid, NrcSfns);
        r.resp_length = 3'd2;
        r.resp_b0 = PosTester;
        r.resp_b1 = SubZero;
      end
      SidDownload: begin
        if (w.req_length < 12'd5) return refuse(w.sid, NrcLen);
        if (sess_q != SessExtended) return refuse(w.sid, NrcCnc);
        if (!may_start(flow_q)) return refuse(w.sid, NrcSeq);
        restart_flow();
        flow_q    = StAccepted;
        outcome_q = ResNone;
        r.resp_length = 3'd5;
        r.resp_b0 = PosDownload;
        r.resp_b1 = cfg_q.length_format_code;
        r.resp_b2 = 8'h00;
        r.resp_b3 = {4'h0, cfg_q.max_block_length[11:8]};
        r.resp_b4 = cfg_q.max_block_length[7:0];
      end
      SidTransfer: begin
        if (w.req_length < 12'd2) return refuse(w.sid, NrcLen);
        if (w.req_length > cfg_q.max_block_length) return refuse(w.sid, NrcRor);
        if (flow_q != StAccepted && flow_q != StXfer) return refuse(w.sid, NrcSeq);
        if (w.byte_one != blk_ctr) begin
          flow_q    = StFailed;
          outcome_q = ResXfail;
          return refuse(w.sid, NrcSeq);
        end
        flow_q = StXfer;
        // wrap only on an exact hit; past the wrap value keep counting mod 256
        if (blk_ctr == cfg_q.counter_wrap_value) blk_ctr = 8'd0;
        else blk_ctr = blk_ctr + 8'd1;
        r.resp_length = 3'd2;
        r.resp_b0 = PosTransfer;
        r.resp_b1 = w.byte_one;
      end
      SidExit: begin
        if (flow_q != StXfer) return refuse(w.sid, NrcSeq);
        flow_q = StDone;
        r.resp_length = 3'd1;
        r.resp_b0 = PosExit;
      end
      SidRoutine: begin
        if (w.req_length < 12'd4) return refuse(w.sid, NrcLen);
        if (sub != SubStart) return refuse(w.sid, NrcSfns);
        rid = {w.byte_two, w.byte_three};
        // equal ids resolve as verify, then activate, then rollback
        if (rid == cfg_q.verify_routine_id) begin
          if (flow_q != StDone) return refuse(w.sid, NrcSeq);
          flow_q = StVerified;
        end else if (rid == cfg_q.activate_routine_id) begin
          if (flow_q != StProg) return refuse(w.sid, NrcSeq);
          flow_q = StPending;
        end else if (rid == cfg_q.rollback_routine_id) begin
          flow_q    = StRollback;
          outcome_q = ResRb;
          report_q  = 1'b1;
          idle_q    = 1'b0;
        end else begin
          return refuse(w.sid, NrcRor);
        end
        r.resp_length = 3'd4;
        r.resp_b0 = PosRoutine;
        r.resp_b1 = sub;
        r.resp_b2 = w.byte_two;
        r.resp_b3 = w.byte_three;
      end
      SidReadId: begin
        if (w.req_length != 12'd3) return refuse(w.sid, NrcLen);
        rid = {w.byte_one, w.byte_two};
        if (rid != cfg_q.status_identifier) return refuse(w.sid, NrcRor);
        r.resp_length = 3'd5;
        r.resp_b0 = PosReadId;
        r.resp_b1 = w.byte_one;
        r.resp_b2 = w.byte_two;
        r.resp_b3 = {4'h0, flow_q};
        r.resp_b4 = {5'h00, outcome_q};
        if ((flow_q == StActivated || flow_q == StRollback) && report_q) begin
          report_q = 1'b0;
          idle_q   = 1'b1;
        end
      end
      default: return refuse(w.sid, NrcSns);
    endcase
    return r;
  endfunction

  // Expected result word of one accepted word
  function automatic res_t predict_answer(input diag_word_t w);
    res_t r;
    r = '0;
    if (w.mode) begin
      if (!w.tx_ok) begin
        outcome_q = ResFail;
        if (flow_q != StIdle && flow_q != StActivated) flow_q = StFailed;
      end else if (idle_q) begin
        flow_q = StIdle;
        restart_flow();
      end
    end else if (w.req_length != 12'd0 && w.req_length <= RxMaxBytes) begin
      r = answer_request(w);
    end
    r.session      = sess_q;
    r.update_state = flow_q;
    r.last_result  = outcome_q;
    return r;
  endfunction

  function automatic diag_word_t mk_req(input int len, input logic [7:0] sid,
                                        input logic [7:0] b1, input logic [7:0] b2,
                                        input logic [7:0] b3);
    diag_word_t w;
    w.mode       = 1'b0;
    w.req_length = len[11:0];
    w.sid        = sid;
    w.byte_one   = b1;
    w.byte_two   = b2;
    w.byte_three = b3;
    w.tx_ok      = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic diag_word_t mk_confirm(input logic ok);
    diag_word_t w;
    w.mode       = 1'b1;
    w.req_length = 12'($urandom_range(4095));
    w.sid        = 8'($urandom_range(255));
    w.byte_one   = 8'($urandom_range(255));
    w.byte_two   = 8'($urandom_range(255));
    w.byte_three = 8'($urandom_range(255));
    w.tx_ok      = ok;
    return w;
  endfunction

  // Zero or, as often as idle_pct sets, a gap that is mostly short and rarely long
  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 12);
    return $urandom_range(3, 1);
  endfunction

  // Next word of a well-formed update sequence from the current predicted state
  function automatic diag_word_t flow_word();
    logic [7:0] sup;
    logic [7:0] ctr;
    int         cap;
    int         len;
    sup = $urandom_range(1) ? 8'h80 : 8'h00;
    if ($urandom_range(19) == 0) begin
      case ($urandom_range(2))
        0: return mk_req($urandom_range(4, 2), SidTester, sup, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        1: return mk_req(3, SidReadId, cfg_q.status_identifier[15:8],
                         cfg_q.status_identifier[7:0], 8'($urandom_range(255)));
        default: return mk_req(2, SidSession, SubDefault | sup, 8'($urandom_range(255)),
                               8'($urandom_range(255)));
      endcase
    end
    case (flow_q)
      StAccepted, StXfer: begin
        if (flow_q == StXfer && $urandom_range(4) == 0)
          return mk_req($urandom_range(3, 1), SidExit, 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)));
        cap = (cfg_q.max_block_length > 12'd40) ? 40 : cfg_q.max_block_length;
        if (cap < 2) len = 2;
        else if ($urandom_range(15) == 0) len = cfg_q.max_block_length;
        else len = $urandom_range(cap, 2);
        ctr = blk_ctr;
        if ($urandom_range(24) == 0) ctr = blk_ctr ^ (8'h01 << $urandom_range(7));
        return mk_req(len, SidTransfer, ctr, 8'($urandom_range(255)),
                      8'($urandom_range(255)));
      end
      StDone:
        return mk_req($urandom_range(6, 4), SidRoutine, SubStart | sup,
                      cfg_q.verify_routine_id[15:8], cfg_q.verify_routine_id[7:0]);
      StVerified:
        return mk_req($urandom_range(4, 2), SidSession, SubProgramming | sup,
                      8'($urandom_range(255)), 8'($urandom_range(255)));
      StProg:
        return mk_req($urandom_range(6, 4), SidRoutine, SubStart | sup,
                      cfg_q.activate_routine_id[15:8], cfg_q.activate_routine_id[7:0]);
      StPending:
        return mk_req($urandom_range(5, 2), SidReset, SubHardReset | sup,
                      8'($urandom_range(255)), 8'($urandom_range(255)));
      default: begin
        if (report_q && (flow_q == StActivated || flow_q == StRollback))
          return mk_req(3, SidReadId, cfg_q.status_identifier[15:8],
                        cfg_q.status_identifier[7:0], 8'($urandom_range(255)));
        if (idle_q) return mk_confirm($urandom_range(7) != 0);
        if (!may_start(flow_q))
          return mk_req($urandom_range(6, 4), SidRoutine, SubStart | sup,
                        cfg_q.rollback_routine_id[15:8], cfg_q.rollback_routine_id[7:0]);
        if (sess_q != SessExtended)
          return mk_req($urandom_range(5, 2), SidSession, SubExtended | sup,
                        8'($urandom_range(255)), 8'($urandom_range(255)));
        return mk_req($urandom_range(12, 5), SidDownload, 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    endcase
  endfunction

  // Random word: any length, known or unknown service, small subfunctions favored
  function automatic diag_word_t noise_word();
    diag_word_t w;
    w.mode = ($urandom_range(5) == 0);
    case ($urandom_range(3))
      0:       w.req_length = 12'($urandom_range(4095));
      1:       w.req_length = 12'($urandom_range(4095, 4000));
      default: w.req_length = 12'($urandom_range(6));
    endcase
    if ($urandom_range(1)) begin
      case ($urandom_range(7))
        0: w.sid = SidSession;
        1: w.sid = SidReset;
        2: w.sid = SidTester;
        3: w.sid = SidDownload;
        4: w.sid = SidTransfer;
        5: w.sid = SidExit;
        6: w.sid = SidRoutine;
        default: w.sid = SidReadId;
      endcase
    end else begin
      w.sid = 8'($urandom_range(255));
    end
    if ($urandom_range(2) == 0) w.byte_one = 8'($urandom_range(255));
    else w.byte_one = {1'($urandom_range(1)), 7'($urandom_range(3))};
    w.byte_two   = 8'($urandom_range(255));
    w.byte_three = 8'($urandom_range(255));
    w.tx_ok      = 1'($urandom_range(1));
    return w;
  endfunction

  // Drive one word and hold it until accepted; record its expected answer
  task automatic send_word(input diag_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= w.mode;
    req_ch.req_length <= w.req_length;
    req_ch.sid        <= w.sid;
    req_ch.byte_one   <= w.byte_one;
    req_ch.byte_two   <= w.byte_two;
    req_ch.byte_three <= w.byte_three;
    req_ch.tx_ok      <= w.tx_ok;
    do @(posedge clk); while (!req_ch.ready);
    answers_due.push_back(predict_answer(w));
  endtask

  // Drop valid and wait until every answer has come back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    wait_idle();
    put_reg(CfgMaxBlock,    {4'h0, c.max_block_length});
    put_reg(CfgCounterWrap, {8'h00, c.counter_wrap_value});
    put_reg(CfgLengthFmt,   {8'h00, c.length_format_code});
    put_reg(CfgVerifyId,    c.verify_routine_id);
    put_reg(CfgActivateId,  c.activate_routine_id);
    put_reg(CfgRollbackId,  c.rollback_routine_id);
    put_reg(CfgStatusId,    c.status_identifier);
    cfg_we <= 1'b0;
    cfg_q = c;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    end
  endtask

  task automatic check_answer();
    res_t want;
    if (answers_due.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected response, expected none, actual length %0d b0 %02h",
               $time, rsp_ch.resp_length, rsp_ch.resp_b0);
    end else begin
      want = answers_due.pop_front();
      compare_field("resp_length",  8'(want.resp_length),  8'(rsp_ch.resp_length));
      compare_field("resp_b0",      want.resp_b0,          rsp_ch.resp_b0);
      compare_field("resp_b1",      want.resp_b1,          rsp_ch.resp_b1);
      compare_field("resp_b2",      want.resp_b2,          rsp_ch.resp_b2);
      compare_field("resp_b3",      want.resp_b3,          rsp_ch.resp_b3);
      compare_field("resp_b4",      want.resp_b4,          rsp_ch.resp_b4);
      compare_field("resp_b5",      want.resp_b5,          rsp_ch.resp_b5);
      compare_field("session",      8'(want.session),      8'(rsp_ch.session));
      compare_field("update_state", 8'(want.update_state), 8'(rsp_ch.update_state));
      compare_field("last_result",  8'(want.last_result),  8'(rsp_ch.last_result));
    end
  endtask

  // Check accepted result words and stall the response side at random
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_answer();
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        hold_left = pick_gap();
      end
    end
  end

  // Every service, some length and subfunction checks, a full update and a rollback
  task automatic test_directed_flow();
    logic [7:0] st_hi;
    logic [7:0] st_lo;
    st_hi = cfg_q.status_identifier[15:8];
    st_lo = cfg_q.status_identifier[7:0];
    idle_pct = 30;
    send_word(mk_req(0, SidTester, SubZero, 8'h00, 8'h00));
    send_word(mk_req(4095, SidTester, 8'h80, 8'hFF, 8'hFF));
    send_word(mk_req(1, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_word(mk_req(1, SidSession, SubDefault, 8'h00, 8'h00));
    send_word(mk_req(2, SidSession, SubProgramming, 8'h00, 8'h00));
    send_word(mk_req(5, SidDownload, 8'h00, 8'h00, 8'h00));
    send_word(mk_req(2, SidSession, SubExtended | 8'h80, 8'h00, 8'h00));
    send_word(mk_req(4, SidDownload, 8'h00, 8'h00, 8'h00));
    send_word(mk_req(5, SidDownload, 8'h00, 8'h44, 8'h00));
    send_word(mk_req(4095, SidTransfer, 8'h01, 8'hAA, 8'h55));
    send_word(mk_req(1, SidExit, 8'h00, 8'h00, 8'h00));
    send_word(mk_req(3, SidReadId, st_hi, st_lo, 8'h00));
    send_word(mk_req(4, SidRoutine, SubStart, cfg_q.verify_routine_id[15:8],
                     cfg_q.verify_routine_id[7:0]));
    send_word(mk_req(2, SidSession, SubProgramming | 8'h80, 8'h00, 8'h00));
    send_word(mk_req(4, SidRoutine, SubStart | 8'h80, cfg_q.activate_routine_id[15:8],
                     cfg_q.activate_routine_id[7:0]));
    send_word(mk_req(2, SidReset, SubHardReset | 8'h80, 8'h00, 8'h00));
    send_word(mk_req(3, SidReadId, st_hi, st_lo, 8'hFF));
    send_word(mk_confirm(1'b0));
    send_word(mk_confirm(1'b1));
    send_word(mk_req(4, SidRoutine, SubStart, cfg_q.rollback_routine_id[15:8],
                     cfg_q.rollback_routine_id[7:0]));
    send_word(mk_req(4, SidRoutine, SubStart, 8'h12, 8'h34));
  endtask

  // Lower the wrap value below the running block counter mid-transfer
  task automatic test_counter_wrap();
    cfg_t c;
    idle_pct = 20;
    send_word(mk_req(2, SidSession, SubExtended, 8'h00, 8'h00));
    send_word(mk_req(5, SidDownload, 8'h00, 8'h00, 8'h00));
    send_word(mk_req(2, SidTransfer, 8'h01, 8'h00, 8'h00));
    send_word(mk_req(3, SidTransfer, 8'h02, 8'h00, 8'h00));
    c = cfg_q;
    c.counter_wrap_value = 8'd1;
    load_config(c);
    send_word(mk_req(2, SidTransfer, 8'h03, 8'h00, 8'h00));
    send_word(mk_req(2, SidTransfer, 8'h04, 8'h00, 8'h00));
  endtask

  // Equal routine ids: verify takes priority over activate and rollback
  task automatic test_routine_priority();
    cfg_t c;
    c = cfg_q;
    c.verify_routine_id   = 16'h5A5A;
    c.activate_routine_id = 16'h5A5A;
    c.rollback_routine_id = 16'h5A5A;
    load_config(c);
    send_word(mk_req(4, SidRoutine, SubStart, 8'h5A, 8'h5A));
    send_word(mk_req(1, SidExit, 8'h00, 8'h00, 8'h00));
    send_word(mk_req(4, SidRoutine, SubStart, 8'h5A, 8'h5A));
  endtask

  // A block limit under two rejects every transfer of valid length as out of range
  task automatic test_block_limit();
    cfg_t c;
    c = cfg_q;
    c.max_block_length = 12'd1;
    load_config(c);
    send_word(mk_req(2, SidTransfer, 8'h05, 8'h00, 8'h00));
  endtask

  // Mostly well-formed update sequences with noise, over several settings
  task automatic test_random_traffic();
    cfg_t c;
    int   phase;
    int   k;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          c.max_block_length    = RstMaxBlock;
          c.counter_wrap_value  = RstCounterWrap;
          c.length_format_code  = RstLengthFmt;
          c.verify_routine_id   = RstVerifyId;
          c.activate_routine_id = RstActivateId;
          c.rollback_routine_id = RstRollbackId;
          c.status_identifier   = RstStatusId;
          idle_pct = 0;
        end
        1: begin
          c = '{12'd4095, 8'd255, 8'hFF, 16'hFFFF, 16'hFFFE, 16'hFFFD, 16'hFFFF};
          idle_pct = 40;
        end
        2: begin
          c = '{12'd2, 8'd1, 8'h00, 16'h0000, 16'h0001, 16'h0002, 16'h0000};
          idle_pct = 60;
        end
        default: begin
          c.max_block_length    = 12'($urandom_range(4095, 2));
          c.counter_wrap_value  = 8'($urandom_range(255, 1));
          c.length_format_code  = 8'($urandom_range(255));
          c.verify_routine_id   = 16'($urandom_range(65535));
          c.activate_routine_id = 16'($urandom_range(65535));
          c.rollback_routine_id = 16'($urandom_range(65535));
          c.status_identifier   = 16'($urandom_range(65535));
          idle_pct = (phase == 3) ? 20 : 50;
        end
      endcase
      load_config(c);
      for (k = 0; k < 165; k++) begin
        if ($urandom_range(99) < 25) send_word(noise_word());
        else send_word(flow_word());
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = 1'b0;
    req_ch.req_length = '0;
    req_ch.sid        = '0;
    req_ch.byte_one   = '0;
    req_ch.byte_two   = '0;
    req_ch.byte_three = '0;
    req_ch.tx_ok      = 1'b0;
    rsp_ch.ready      = 1'b0;
    idle_pct          = 0;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_flow();
    test_counter_wrap();
    test_routine_priority();
    test_block_limit();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
